FILE: rtl/mfa_pkg.sv
// Package for the mixed fraction ALU: operation codes, widths and shared types.
// No dependencies.
package mfa_pkg;

  localparam int WW = 40;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic start;
    logic [WW-1:0] a;
    logic [WW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [WW-1:0] quo;
    logic [WW-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/mfa_divider.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on mfa_pkg.
module mfa_divider
  import mfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [WW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [WW:0]   trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r, q_r[WW-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.a;
      r_nxt = '0;
      d_nxt = req.b;
      cnt_nxt = 6'(WW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[WW]) begin
        r_nxt = trial[WW-1:0];
        q_nxt = {q_r[WW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WW-2:0], q_r[WW-1]};
        q_nxt = {q_r[WW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo = q_r;
  assign rsp.rem = r_r;

endmodule

FILE: rtl/mixed_fraction_alu.sv
// Top level of the mixed fraction ALU: operand check, sequencer and output register.
// Depends on mfa_pkg and mfa_divider.
//
// Channel | Direction | Contents
// in_     | slave     | tdata: kind, a_whole, a_num, a_den, b_whole, b_num, b_den
// out_    | master    | tdata: res_whole, res_num, res_den; tuser: bad_operand
//
// The shared divider performs every GCD step, the LCM quotient, the two scale factors,
// the reduction of numerator and denominator and the final split into whole part and
// remainder.
// An invalid operand goes straight to the output state without using the divider.
// Reset is synchronous and clears the sequencer. A stalled result is held in the
// output register, and no new transaction is taken until it has gone.
module mixed_fraction_alu
  import mfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[1:0], a_whole[9:2], a_num[18:10], a_den[26:19], b_whole[34:27],
  // b_num[43:35], b_den[51:44], zero fill[55:52]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // res_whole[16:0], res_num[33:17], res_den[49:34], zero fill[55:50]
  output logic [55:0] out_tdata,
  // bad_operand[0]
  output logic        out_tuser
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PREP = 10'b0000000010,
    S_GCD1 = 10'b0000000100,
    S_LCM  = 10'b0000001000,
    S_SCL1 = 10'b0000010000,
    S_SCL2 = 10'b0000100000,
    S_GCD2 = 10'b0001000000,
    S_RED  = 10'b0010000000,
    S_SPLT = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic signed [WW-1:0] n1_r, n1_nxt, n2_r, n2_nxt, rn_r, rn_nxt;
  logic [WW-1:0] d1_r, d1_nxt, d2_r, d2_nxt, rd_r, rd_nxt, x_r, x_nxt, y_r, y_nxt;
  logic          wait_r, wait_nxt, neg_r, neg_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [55:0]   tdata_r, tdata_nxt;
  logic          tuser_r, tuser_nxt, ovalid_r, ovalid_nxt;
  div_req_t      dreq;
  div_rsp_t      drsp;

  logic signed [7:0] aw, bw;
  logic signed [8:0] an, bn;
  logic [7:0]        ad, bd;
  logic              abad, bbad;
  logic [7:0]        ade, bde;
  logic [WW-1:0]     mul_p;
  logic [WW-1:0]     rn_mag;
  logic signed [16:0] wh_o, rem_o;

  assign aw = in_tdata[9:2];
  assign an = in_tdata[18:10];
  assign ad = in_tdata[26:19];
  assign bw = in_tdata[34:27];
  assign bn = in_tdata[43:35];
  assign bd = in_tdata[51:44];
  assign abad = (ad == 8'd0 && an != 9'sd0) || (an < 0 && aw != 8'sd0) ||
                (an == 9'sd0 && aw == 8'sd0);
  assign bbad = (bd == 8'd0 && bn != 9'sd0) || (bn < 0 && bw != 8'sd0) ||
                (bn == 9'sd0 && bw == 8'sd0);
  assign ade = (ad == 8'd0) ? 8'd1 : ad;
  assign bde = (bd == 8'd0) ? 8'd1 : bd;
  assign rn_mag = rn_r[WW-1] ? WW'(-rn_r) : WW'(rn_r);

  function automatic logic signed [WW-1:0] improper(logic signed [7:0] w,
      logic signed [8:0] n, logic [7:0] d);
    logic [7:0] wm;
    logic signed [WW-1:0] v;
    wm = w[7] ? 8'(-w) : 8'(w);
    v = WW'(n) + $signed(WW'({8'd0, wm} * {8'd0, d}));
    return w[7] ? -v : v;
  endfunction

  function automatic logic signed [WW-1:0] smul(logic signed [16:0] a,
      logic signed [17:0] b);
    logic signed [34:0] p;
    p = a * b;
    return WW'(p);
  endfunction

  mfa_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (dreq),
    .rsp (drsp)
  );

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    n1_nxt = n1_r; n2_nxt = n2_r; d1_nxt = d1_r; d2_nxt = d2_r;
    rn_nxt = rn_r; rd_nxt = rd_r; x_nxt = x_r; y_nxt = y_r;
    wait_nxt = wait_r; neg_nxt = neg_r; step_nxt = step_r;
    tdata_nxt = tdata_r; tuser_nxt = tuser_r;
    ovalid_nxt = ovalid_r && !out_tready;
    dreq = '0;
    mul_p = '0;
    wh_o = '0;
    rem_o = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = op_t'(in_tdata[1:0]);
          n1_nxt = improper(aw, an, ade);
          n2_nxt = improper(bw, bn, bde);
          d1_nxt = WW'(ade);
          d2_nxt = WW'(bde);
          if (abad || bbad) begin
            tdata_nxt = '0;
            tuser_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        step_nxt = '0;
        wait_nxt = 1'b0;
        if (op_r == OP_ADD || op_r == OP_SUB) begin
          x_nxt = d1_r;
          y_nxt = d2_r;
          state_nxt = S_GCD1;
        end else if (op_r == OP_MUL) begin
          rn_nxt = smul($signed(n1_r[16:0]), $signed(n2_r[17:0]));
          rd_nxt = WW'(d1_r[7:0] * d2_r[7:0]);
          state_nxt = S_GCD2;
          x_nxt = '0;
        end else begin
          rn_nxt = n2_r[WW-1] ? -smul($signed(n1_r[16:0]), $signed({10'd0, d2_r[7:0]}))
                              : smul($signed(n1_r[16:0]), $signed({10'd0, d2_r[7:0]}));
          rd_nxt = WW'(d1_r[7:0] * (n2_r[WW-1] ? 17'(-n2_r) : 17'(n2_r)));
          state_nxt = S_GCD2;
        end
      end
      S_GCD1: begin
        if (!wait_r) begin
          if (y_r == '0) begin
            state_nxt = S_LCM;
          end else begin
            dreq.start = 1'b1;
            dreq.a = x_r;
            dreq.b = y_r;
            wait_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          x_nxt = y_r;
          y_nxt = drsp.rem;
          wait_nxt = 1'b0;
        end
      end
      S_LCM: begin
        mul_p = WW'(d1_r[7:0] * d2_r[7:0]);
        if (!wait_r) begin
          dreq.start = 1'b1;
          dreq.a = mul_p;
          dreq.b = x_r;
          wait_nxt = 1'b1;
        end else if (drsp.done) begin
          rd_nxt = drsp.quo;
          wait_nxt = 1'b0;
          state_nxt = S_SCL1;
        end
      end
      S_SCL1: begin
        if (!wait_r) begin
          dreq.start = 1'b1;
          dreq.a = rd_r;
          dreq.b = (step_r == 2'd0) ? d1_r : d2_r;
          wait_nxt = 1'b1;
        end else if (drsp.done) begin
          wait_nxt = 1'b0;
          if (step_r == 2'd0) begin
            x_nxt = drsp.quo;
            step_nxt = 2'd1;
          end else begin
            y_nxt = drsp.quo;
            state_nxt = S_SCL2;
          end
        end
      end
      S_SCL2: begin
        if (step_r == 2'd1) begin
          n1_nxt = smul($signed(n1_r[16:0]), $signed({1'b0, x_r[16:0]}));
          n2_nxt = smul($signed(n2_r[16:0]), $signed({1'b0, y_r[16:0]}));
          step_nxt = 2'd2;
        end else begin
          rn_nxt = (op_r == OP_ADD) ? n1_r + n2_r : n1_r - n2_r;
          state_nxt = S_GCD2;
          step_nxt = 2'd0;
        end
      end
      S_GCD2: begin
        if (step_r == 2'd0) begin
          x_nxt = rn_mag;
          y_nxt = rd_r;
          step_nxt = 2'd1;
        end else if (!wait_r) begin
          if (y_r == '0) begin
            state_nxt = S_RED;
            step_nxt = 2'd0;
          end else begin
            dreq.start = 1'b1;
            dreq.a = x_r;
            dreq.b = y_r;
            wait_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          x_nxt = y_r;
          y_nxt = drsp.rem;
          wait_nxt = 1'b0;
        end
      end
      S_RED: begin
        if (!wait_r) begin
          dreq.start = 1'b1;
          dreq.a = (step_r == 2'd0) ? rn_mag : rd_r;
          dreq.b = x_r;
          wait_nxt = 1'b1;
        end else if (drsp.done) begin
          wait_nxt = 1'b0;
          if (step_r == 2'd0) begin
            neg_nxt = rn_r[WW-1];
            rn_nxt = drsp.quo;
            step_nxt = 2'd1;
          end else begin
            rd_nxt = drsp.quo;
            state_nxt = S_SPLT;
          end
        end
      end
      S_SPLT: begin
        if (!wait_r) begin
          dreq.start = 1'b1;
          dreq.a = rn_r;
          dreq.b = rd_r;
          wait_nxt = 1'b1;
        end else if (drsp.done) begin
          wait_nxt = 1'b0;
          wh_o = neg_r ? 17'(-drsp.quo) : 17'(drsp.quo);
          rem_o = (neg_r && drsp.quo == '0) ? 17'(-drsp.rem) : 17'(drsp.rem);
          tdata_nxt = {6'd0, rd_r[15:0], rem_o, wh_o};
          tuser_nxt = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      wait_r <= 1'b0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      wait_r <= wait_nxt;
      step_r <= step_nxt;
    end
    op_r <= op_nxt;
    n1_r <= n1_nxt; n2_r <= n2_nxt; d1_r <= d1_nxt; d2_r <= d2_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; x_r <= x_nxt; y_r <= y_nxt;
    neg_r <= neg_nxt;
    tdata_r <= tdata_nxt;
    tuser_r <= tuser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

endmodule

FILE: rtl/mfa_checker.sv
// Port-level checker for the mixed fraction ALU, bound to the top level.
// Depends on mixed_fraction_alu.
module mfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result changed while stalled.");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("Invalid operand result is not zero.");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("More than one result for a transaction.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("Input taken while a result waits.");

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second transaction accepted while busy.");

endmodule

bind mixed_fraction_alu mfa_checker u_mfa_checker (
  .clk (clk),
  .rst_n (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

FILE: test/tb_top.sv
// Testbench for mixed_fraction_alu: directed and random mixed fraction operations,
// checked field by field against a behavioural predictor. Depends on mfa_pkg and mixed_fraction_alu.
`timescale 1ns / 1ps
module tb_top;
  import mfa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;

  typedef struct {
    logic signed [16:0] whole;
    logic signed [16:0] num;
    logic [15:0]        den;
    logic               bad;
  } frac_res_t;

  frac_res_t   pending_results[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  bit          hold_off = 0;
  bit          drain_random = 1;

  mixed_fraction_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 8000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint gcd_of(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic bit improper_of(longint w, longint n, longint d,
                                     output longint on, output longint od);
    on = 0;
    od = 0;
    if ((d == 0 && n != 0) || (n < 0 && w != 0) || (n == 0 && w == 0)) return 0;
    if (d == 0) d = 1;
    on = n + absval(w) * d;
    if (w < 0) on = -on;
    od = d;
    return 1;
  endfunction

  function automatic frac_res_t predict_fraction(op_t op, logic signed [7:0] aw,
      logic signed [8:0] an, logic [7:0] ad, logic signed [7:0] bw,
      logic signed [8:0] bn, logic [7:0] bd);
    frac_res_t r;
    longint n1, d1, n2, d2, rn, rd, g, l, wh, rem;
    bit ok1, ok2;
    ok1 = improper_of(aw, an, ad, n1, d1);
    ok2 = improper_of(bw, bn, bd, n2, d2);
    if (!ok1 || !ok2) begin
      r.whole = 0; r.num = 0; r.den = 0; r.bad = 1;
      return r;
    end
    case (op)
      OP_ADD, OP_SUB: begin
        l = d1 * d2 / gcd_of(d1, d2);
        rn = (op == OP_ADD) ? n1 * (l / d1) + n2 * (l / d2)
                            : n1 * (l / d1) - n2 * (l / d2);
        rd = l;
      end
      OP_MUL: begin
        rn = n1 * n2;
        rd = d1 * d2;
      end
      default: begin
        rn = (n2 < 0) ? -(n1 * d2) : n1 * d2;
        rd = d1 * absval(n2);
      end
    endcase
    g = gcd_of(absval(rn), rd);
    rn = rn / g;
    rd = rd / g;
    wh = rn / rd;
    rem = rn % rd;
    if (wh < 0 && rem < 0) rem = -rem;
    r.whole = wh[16:0]; r.num = rem[16:0]; r.den = rd[15:0]; r.bad = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_fraction_op(op_t op, logic signed [7:0] aw, logic signed [8:0] an,
      logic [7:0] ad, logic signed [7:0] bw, logic signed [8:0] bn, logic [7:0] bd);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {4'b0, bd, bn, bw, ad, an, aw, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_fraction(op, aw, an, ad, bw, bn, bd));
  endtask

  // The receiver draws a random stall before each result while drain_random is set, and can be held off entirely.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = drain_random ? $urandom_range(0, 5) : 0;
      if (stall != 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    frac_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[16:0] !== exp_r.whole)
          report_mismatch("res_whole", $signed(out_tdata[16:0]), exp_r.whole);
        if (out_tdata[33:17] !== exp_r.num)
          report_mismatch("res_num", $signed(out_tdata[33:17]), exp_r.num);
        if (out_tdata[49:34] !== exp_r.den)
          report_mismatch("res_den", out_tdata[49:34], exp_r.den);
        if (out_tuser !== exp_r.bad)
          report_mismatch("bad_operand", out_tuser, exp_r.bad);
      end
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    op_t op;
    op = op.first();
    do begin
      send_fraction_op(op, 8'sd1, 9'sd1, 8'd2, 8'sd0, 9'sd3, 8'd4);
      send_fraction_op(op, -8'sd128, 9'sd255, 8'd255, 8'sd127, 9'sd255, 8'd255);
      send_fraction_op(op, 8'sd127, 9'sd0, 8'd0, -8'sd3, 9'sd0, 8'd0);
      send_fraction_op(op, 8'sd0, -9'sd255, 8'd1, 8'sd0, -9'sd7, 8'd9);
      op = op.next();
    end while (op != op.first());
    send_fraction_op(OP_ADD, 8'sd0, 9'sd5, 8'd0, 8'sd1, 9'sd1, 8'd2);
    send_fraction_op(OP_SUB, 8'sd2, -9'sd1, 8'd3, 8'sd1, 9'sd1, 8'd2);
    send_fraction_op(OP_MUL, 8'sd0, 9'sd0, 8'd5, 8'sd1, 9'sd1, 8'd2);
    send_fraction_op(OP_SUB, 8'sd1, 9'sd1, 8'd2, 8'sd1, 9'sd1, 8'd2);
    send_fraction_op(OP_DIV, 8'sd0, 9'sd0, 8'd0, 8'sd0, 9'sd0, 8'd0);
    send_fraction_op(OP_ADD, 8'sd0, -9'sd256, 8'd255, 8'sd0, 9'sd1, 8'd1);
    wait_drained();
  endtask

  task automatic random_operand(output logic signed [7:0] w, output logic signed [8:0] n,
                                output logic [7:0] d);
    int sel;
    sel = $urandom_range(0, 19);
    w = 8'($urandom);
    d = 8'($urandom);
    n = 9'($urandom_range(0, 255));
    if (sel < 3) begin
      n = 9'($urandom);
    end else if (sel < 5) begin
      n = 0;
      d = 0;
    end else if (sel < 8) begin
      w = 0;
      n = 9'($urandom);
    end else if (sel < 9) begin
      d = 0;
    end
    if (d == 0 && n != 0 && sel >= 3) d = 8'($urandom_range(1, 255));
  endtask

  task automatic test_random(int count);
    logic signed [7:0] aw, bw;
    logic signed [8:0] an, bn;
    logic [7:0]        ad, bd;
    repeat (count) begin
      random_operand(aw, an, ad);
      random_operand(bw, bn, bd);
      send_fraction_op(op_t'($urandom_range(0, 3)), aw, an, ad, bw, bn, bd);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      test_random(10);
    join
    drain_random = 0;
    test_random(30);
    drain_random = 1;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(600);
    wait_drained();
    repeat (1000) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mfa_pkg.sv
rtl/mfa_divider.sv
rtl/mixed_fraction_alu.sv
rtl/mfa_checker.sv
test/tb_top.sv
